[hw/rtl/gets_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gets_pkg
// Shared constants and codes for the toggleable-edge shortest path block.
// ----------------------------------------------------------------------------
package gets_pkg;

  localparam int NODE_COUNT_DEF  = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int NODE_FIELD_BITS = 6;
  localparam int IN_WEIGHT_BITS  = 16;
  localparam int CMD_BITS        = 3;
  localparam int STATUS_BITS     = 3;
  localparam int DIST_BITS       = 22;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  localparam logic [CMD_BITS-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_TOGGLE = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_STATUS = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_CONN   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_DIST   = 3'd4;

  localparam logic [STATUS_BITS-1:0] STAT_DONE     = 3'd0;
  localparam logic [STATUS_BITS-1:0] STAT_OPEN     = 3'd1;
  localparam logic [STATUS_BITS-1:0] STAT_CLOSED   = 3'd2;
  localparam logic [STATUS_BITS-1:0] STAT_NO_EDGE  = 3'd3;
  localparam logic [STATUS_BITS-1:0] STAT_CONN     = 3'd4;
  localparam logic [STATUS_BITS-1:0] STAT_NOT_CONN = 3'd5;

endpackage : gets_pkg
`default_nettype wire

[hw/rtl/gets_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gets_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module gets_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : gets_ram
`default_nettype wire

[hw/rtl/gets_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gets_alu
// Shared saturating add and less-than compare used by scan and relax steps.
// ----------------------------------------------------------------------------
module gets_alu #(
  parameter int WB = gets_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic [gets_pkg::DIST_BITS-1:0] base,
  input  wire logic [WB-1:0]                  addend,
  input  wire logic [gets_pkg::DIST_BITS-1:0] limit,
  output logic      [gets_pkg::DIST_BITS-1:0] sum,
  output logic                                less
);
  import gets_pkg::*;

  localparam int SW = ((WB > DIST_BITS) ? WB : DIST_BITS) + 1;

  logic [SW-1:0] full;

  always_comb begin
    full = SW'(base) + SW'(addend);
    if (full > SW'(DIST_MAX)) begin
      sum = DIST_MAX;
    end else begin
      sum = full[DIST_BITS-1:0];
    end
    less = (sum < limit);
  end

endmodule : gets_alu
`default_nettype wire

[hw/rtl/graph_edge_toggle_shortest_path.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// graph_edge_toggle_shortest_path
// Undirected weighted graph in an adjacency matrix memory with open/closed
// edges, connectivity test and shortest open-path distance.
//
// Input beats on s_*: s_tuser carries the command, s_tdata node_a, node_b
// and edge_weight. One result beat per command on m_*: m_tuser carries status
// and reachable, m_tdata the unsigned 22-bit integer distance.
// After reset the matrix memory is cleared, one entry a cycle, over all
// 2^(2*ceil(log2 NODE_COUNT)) entries (4096 at 64 nodes); s_tready stays low
// until then.
// One command is handled at a time. Add, toggle and status pass through
// dispatch, their matrix steps and the result register. A search settles
// nodes one by one: each settled node costs a scan over the distance memory
// plus a relax pass over one matrix row, all through one shared
// add/compare unit.
// A finished result sits in the output register; the next command is taken
// meanwhile, and a later result waits until m_tready drains the first.
// ----------------------------------------------------------------------------
module graph_edge_toggle_shortest_path #(
  parameter int NODE_COUNT  = gets_pkg::NODE_COUNT_DEF,
  parameter int WEIGHT_BITS = gets_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // node_a[5:0], node_b[11:6], edge_weight[27:12]
  input  wire logic [2:0]  s_tuser,   // command[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // distance[21:0]
  output logic      [3:0]  m_tuser    // status[2:0], reachable[3]
);
  import gets_pkg::*;

  localparam int NB = $clog2(NODE_COUNT);
  localparam int AW = 2 * NB;
  localparam int WB = WEIGHT_BITS;
  localparam int DW = WB + 2;
  localparam int IW = ((NB > NODE_FIELD_BITS) ? NB : NODE_FIELD_BITS) + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_ADD2, S_TG_EVAL, S_TG_W2, S_INIT,
    S_SCAN, S_PICK, S_RELAX, S_FIN, S_FIN_RD, S_OUT
  } state_t;

  state_t state;

  logic [CMD_BITS-1:0]    cmd;
  logic [NB-1:0]          na, nb;
  logic [WB-1:0]          nw;
  logic                   rng;
  logic                   same;
  logic [STATUS_BITS-1:0] res_status;
  logic [DIST_BITS-1:0]   res_dist;
  logic                   res_reach;
  logic [DW-1:0]          tg_word;
  logic [AW-1:0]          clr_cnt;
  logic [NODE_COUNT-1:0]  node_present, reached, settled;
  logic [NB:0]            cnt;
  logic                   p_vld;
  logic [NB-1:0]          p_idx;
  logic                   found;
  logic [NB-1:0]          u;
  logic [DIST_BITS-1:0]   best;

  logic [IW-1:0] a_ext, b_ext;
  logic          issue, last;

  logic          e_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [DW-1:0] e_wdata, e_rdata;

  logic                 d_we;
  logic [NB-1:0]        d_waddr, d_raddr;
  logic [DIST_BITS-1:0] d_wdata, d_rdata;

  logic [DIST_BITS-1:0] alu_base, alu_limit, alu_sum;
  logic [WB-1:0]        alu_add;
  logic                 alu_less;
  logic                 relax_hit;

  assign a_ext = IW'(s_tdata[5:0]);
  assign b_ext = IW'(s_tdata[11:6]);
  assign issue = (cnt < (NB+1)'(NODE_COUNT));
  assign last  = p_vld && (p_idx == NB'(NODE_COUNT - 1));
  assign s_tready = (state == S_IDLE);

  // shared unit: min compare while scanning, add and compare while relaxing
  always_comb begin
    if (state == S_RELAX) begin
      alu_base  = best;
      alu_add   = e_rdata[WB-1:0];
      alu_limit = d_rdata;
    end else begin
      alu_base  = d_rdata;
      alu_add   = '0;
      alu_limit = best;
    end
  end

  gets_alu #(.WB(WB)) u_alu (
    .base(alu_base), .addend(alu_add), .limit(alu_limit),
    .sum(alu_sum), .less(alu_less)
  );

  assign relax_hit = p_vld && e_rdata[DW-1] && e_rdata[DW-2] && !settled[p_idx]
                     && (!reached[p_idx] || alu_less);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = {na, nb};
    e_wdata = {1'b1, 1'b1, nw};
    e_raddr = {na, nb};
    case (state)
      S_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_cnt;
        e_wdata = '0;
      end
      S_DISPATCH: e_we = (cmd == CMD_ADD) && rng;
      S_ADD2: begin
        e_we    = 1'b1;
        e_waddr = {nb, na};
      end
      S_TG_EVAL: begin
        e_we    = (cmd == CMD_TOGGLE) && e_rdata[DW-1];
        e_wdata = {1'b1, ~e_rdata[DW-2], e_rdata[WB-1:0]};
      end
      S_TG_W2: begin
        e_we    = 1'b1;
        e_waddr = {nb, na};
        e_wdata = tg_word;
      end
      S_RELAX: e_raddr = {u, cnt[NB-1:0]};
      default: e_we = 1'b0;
    endcase
  end

  always_comb begin
    d_we    = 1'b0;
    d_waddr = p_idx;
    d_wdata = alu_sum;
    d_raddr = cnt[NB-1:0];
    case (state)
      S_INIT: begin
        d_we    = 1'b1;
        d_waddr = na;
        d_wdata = '0;
      end
      S_RELAX: d_we = relax_hit;
      S_FIN:   d_raddr = nb;
      default: d_we = 1'b0;
    endcase
  end

  gets_ram #(.DW(DW), .AW(AW)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  gets_ram #(.DW(DIST_BITS), .AW(NB)) u_dist_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      node_present <= '0;
      reached      <= '0;
      settled      <= '0;
      m_tvalid     <= 1'b0;
      p_vld        <= 1'b0;
      found        <= 1'b0;
      cnt          <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd        <= s_tuser;
            na         <= a_ext[NB-1:0];
            nb         <= b_ext[NB-1:0];
            nw         <= WB'(s_tdata[27:12]);
            rng        <= (a_ext < IW'(NODE_COUNT)) && (b_ext < IW'(NODE_COUNT));
            same       <= (a_ext == b_ext);
            res_status <= STAT_DONE;
            res_dist   <= '0;
            res_reach  <= 1'b0;
            state      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= S_OUT;
          case (cmd)
            CMD_ADD: begin
              if (rng) begin
                node_present[na] <= 1'b1;
                node_present[nb] <= 1'b1;
                state <= S_ADD2;
              end
            end
            CMD_TOGGLE, CMD_STATUS: begin
              if (rng) begin
                state <= S_TG_EVAL;
              end else if (cmd == CMD_STATUS) begin
                res_status <= STAT_NO_EDGE;
              end
            end
            CMD_CONN: begin
              if (!(rng && node_present[na] && node_present[nb])) begin
                res_status <= STAT_NOT_CONN;
              end else if (na == nb) begin
                res_status <= STAT_CONN;
              end else begin
                state <= S_INIT;
              end
            end
            CMD_DIST: begin
              // same source and target counts as reached even when absent
              if (same) begin
                res_reach <= 1'b1;
              end else if (rng) begin
                state <= S_INIT;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_ADD2: state <= S_OUT;
        S_TG_EVAL: begin
          tg_word <= e_wdata;
          state   <= S_OUT;
          if (cmd == CMD_STATUS) begin
            if (!e_rdata[DW-1]) begin
              res_status <= STAT_NO_EDGE;
            end else if (e_rdata[DW-2]) begin
              res_status <= STAT_OPEN;
            end else begin
              res_status <= STAT_CLOSED;
            end
          end else if (e_rdata[DW-1]) begin
            state <= S_TG_W2;
          end
        end
        S_TG_W2: state <= S_OUT;
        S_INIT: begin
          reached <= NODE_COUNT'(1) << na;
          settled <= '0;
          cnt     <= '0;
          p_vld   <= 1'b0;
          found   <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          p_vld <= issue;
          p_idx <= cnt[NB-1:0];
          // strict compare keeps the lowest index among equal minima
          if (p_vld && reached[p_idx] && !settled[p_idx] && (!found || alu_less)) begin
            u     <= p_idx;
            best  <= d_rdata;
            found <= 1'b1;
          end
          if (last) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          cnt   <= '0;
          p_vld <= 1'b0;
          if (found) begin
            settled[u] <= 1'b1;
            state      <= S_RELAX;
          end else begin
            state <= S_FIN;
          end
        end
        S_RELAX: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          p_vld <= issue;
          p_idx <= cnt[NB-1:0];
          if (relax_hit) begin
            reached[p_idx] <= 1'b1;
          end
          if (last) begin
            cnt   <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_FIN: begin
          if (reached[nb]) begin
            state <= S_FIN_RD;
          end else begin
            if (cmd == CMD_CONN) begin
              res_status <= STAT_NOT_CONN;
            end
            state <= S_OUT;
          end
        end
        S_FIN_RD: begin
          if (cmd == CMD_CONN) begin
            res_status <= STAT_CONN;
          end else begin
            res_dist  <= d_rdata;
            res_reach <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_dist};
            m_tuser  <= {res_reach, res_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("input taken during matrix clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat accepted while busy");

  a_reach_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] == STAT_DONE))
    else $error("reachable with non-done status");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[3]) |-> (m_tdata == '0))
    else $error("distance nonzero when unreachable");

endmodule : graph_edge_toggle_shortest_path
`default_nettype wire
